// ===== hw/rtl/nnr_pkg.sv =====
// Shared types and constants of the nearest node to ray search block.
package nnr_pkg;

  localparam int COORD_W     = 20;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int DIR_W       = 16;
  localparam int AXES        = 3;
  localparam int IDX_W       = 16;
  localparam int MAX_NODES   = 65536;
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int DIST_W      = 44;
  localparam int OUT_DIST_W  = 45;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int T_W         = DIFF_W + DIR_W + 2;
  localparam int T_LO_W      = 19;
  localparam int T_HI_W      = T_W - T_LO_W;
  localparam int HI_W        = T_HI_W + DIR_W;
  localparam int MUL_W       = 26;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ROUND_SH    = 30;
  localparam int E_FULL_W    = 57;
  localparam int E_W         = 26;
  localparam int SUM_W       = PROD_W + 2;

  localparam int IN_DATA_W   = 112;
  localparam int DIR_LSB     = AXES * COORD_W;
  localparam int MODE_BIT    = DIR_LSB + AXES * DIR_W;
  localparam int OUT_DATA_W  = 64;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic signed [E_FULL_W-1:0] ROUND_HALF = E_FULL_W'(1) << (ROUND_SH - 1);

  typedef struct packed {
    logic                             clear;
    logic                             node;
    logic                             last;
    logic                             mode;
    logic [IDX_W-1:0]                 idx;
    logic [AXES-1:0][DIR_W-1:0]       dir;
    logic [AXES-1:0][DIFF_W-1:0]      d;
  } q_entry_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DOT,
    B_SUMT,
    B_PH,
    B_PL,
    B_ERR,
    B_SQ,
    B_CMP,
    B_RES
  } back_state_t;

endpackage

// ===== hw/rtl/nnr_front.sv =====
// Front end: accepts items, keeps the query and the node count, builds queue entries.
module nnr_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, mode, zero fill
  input  logic [nnr_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              q_full,
  output logic                              push,
  output nnr_pkg::q_entry_t                 entry
);
  import nnr_pkg::*;

  logic [AXES-1:0][COORD_W-1:0] origin_r, origin_nxt;
  logic [AXES-1:0][DIR_W-1:0]   dir_r, dir_nxt;
  logic                         mode_r, mode_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         room;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;
  assign room      = cnt_r < CNT_W'(MAX_NODES);

  always_comb begin
    origin_nxt = origin_r;
    dir_nxt    = dir_r;
    mode_nxt   = mode_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      if (!in_tuser) begin
        for (int i = 0; i < AXES; i++) begin
          origin_nxt[i] = in_tdata[COORD_W*i +: COORD_W];
          dir_nxt[i]    = in_tdata[DIR_LSB + DIR_W*i +: DIR_W];
        end
        mode_nxt = in_tdata[MODE_BIT];
        cnt_nxt  = '0;
      end else if (room) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (in_tlast) begin
        cnt_nxt = '0;
      end
    end
  end

  always_comb begin
    entry.clear = !in_tuser;
    entry.node  = in_tuser && room;
    entry.last  = in_tlast;
    entry.mode  = mode_r;
    entry.idx   = cnt_r[IDX_W-1:0];
    entry.dir   = dir_r;
    for (int i = 0; i < AXES; i++) begin
      entry.d[i] = DIFF_W'($signed(in_tdata[COORD_W*i +: COORD_W]))
                 - DIFF_W'($signed(origin_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      dir_r    <= '0;
      mode_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      origin_r <= origin_nxt;
      dir_r    <= dir_nxt;
      mode_r   <= mode_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/nnr_queue.sv =====
// Short entry queue between the front end and the distance engine.
module nnr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  nnr_pkg::q_entry_t wr_entry,
  input  logic              pop,
  output nnr_pkg::q_entry_t head,
  output logic              empty,
  output logic              full
);
  import nnr_pkg::*;

  q_entry_t            entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_pop;

  assign empty  = count_r == '0;
  assign full   = count_r == QCNT_W'(QUEUE_DEPTH);
  assign head   = entries_r[rd_ptr_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/nnr_back.sv =====
// Distance engine: sequences projection, error and squared distance, keeps the best node.
module nnr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  nnr_pkg::q_entry_t              head,
  input  logic                           q_empty,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // best_index, best_dist_sq, zero fill
  output logic [nnr_pkg::OUT_DATA_W-1:0] out_tdata,
  // found
  output logic                           out_tuser
);
  import nnr_pkg::*;

  back_state_t               state_r, state_nxt;
  logic signed [T_W-1:0]     t_r, t_nxt;
  logic signed [PROD_W-1:0]  prod_r [AXES];
  logic signed [HI_W-1:0]    hi_r [AXES];
  logic signed [E_W-1:0]     e_r [AXES];
  logic signed [MUL_W-1:0]   op_a [AXES];
  logic signed [MUL_W-1:0]   op_b [AXES];
  logic signed [E_FULL_W-1:0] e_full [AXES];
  logic signed [E_FULL_W-1:0] e_rnd [AXES];
  logic [SUM_W-1:0]          sum;
  logic [DIST_W-1:0]         dist_sq;
  logic [DIST_W-1:0]         best_dist_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic                      have_best_r;
  logic                      out_valid_r, out_valid_nxt;
  logic                      found_r;
  logic [IDX_W-1:0]          idx_out_r;
  logic [OUT_DIST_W-1:0]     dist_out_r;
  logic                      out_free;
  logic                      t_neg;
  logic                      clr_best;
  logic                      upd_best;
  logic                      out_load;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    t_nxt = '0;
    for (int i = 0; i < AXES; i++) begin
      t_nxt = t_nxt + $signed(prod_r[i][T_W-1:0]);
    end
  end
  assign t_neg = t_nxt[T_W-1];

  always_comb begin
    sum = '0;
    for (int i = 0; i < AXES; i++) begin
      sum = sum + SUM_W'(prod_r[i][PROD_W-1:0]);
    end
    dist_sq = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      e_full[i] = (E_FULL_W'($signed(head.d[i])) <<< ROUND_SH)
                - (E_FULL_W'(hi_r[i]) <<< T_LO_W) - E_FULL_W'(prod_r[i]);
      e_rnd[i]  = e_full[i] + ROUND_HALF;
    end
  end

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      op_a[i] = MUL_W'($signed(head.d[i]));
      op_b[i] = MUL_W'($signed(head.dir[i]));
      case (state_r)
        B_PH: begin
          op_a[i] = MUL_W'($signed(t_r[T_W-1:T_LO_W]));
        end
        B_PL: begin
          op_a[i] = MUL_W'({1'b0, t_r[T_LO_W-1:0]});
        end
        B_SQ: begin
          op_a[i] = head.mode ? e_r[i] : MUL_W'($signed(head.d[i]));
          op_b[i] = op_a[i];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (head.node) begin
            state_nxt = head.mode ? B_DOT : B_SQ;
          end else if (head.last) begin
            state_nxt = B_RES;
          end
        end
      end
      B_DOT:  state_nxt = B_SUMT;
      B_SUMT: begin
        if (t_neg) begin
          state_nxt = head.last ? B_RES : B_IDLE;
        end else begin
          state_nxt = B_PH;
        end
      end
      B_PH:   state_nxt = B_PL;
      B_PL:   state_nxt = B_ERR;
      B_ERR:  state_nxt = B_SQ;
      B_SQ:   state_nxt = B_CMP;
      B_CMP:  state_nxt = head.last ? B_RES : B_IDLE;
      B_RES: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    clr_best = 1'b0;
    upd_best = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        clr_best = !q_empty && head.clear;
        pop      = !q_empty && !head.node && !head.last;
      end
      B_SUMT: begin
        pop = t_neg && !head.last;
      end
      B_CMP: begin
        upd_best = !have_best_r || (dist_sq < best_dist_r);
        pop      = !head.last;
      end
      B_RES: begin
        out_load = out_free;
        clr_best = out_free;
        pop      = out_free;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    for (int i = 0; i < AXES; i++) begin
      prod_r[i] <= op_a[i] * op_b[i];
      if (state_r == B_PL) begin
        hi_r[i] <= prod_r[i][HI_W-1:0];
      end
      if (state_r == B_ERR) begin
        e_r[i] <= e_rnd[i][ROUND_SH +: E_W];
      end
    end
    if (state_r == B_SUMT) begin
      t_r <= t_nxt;
    end
    if (out_load) begin
      found_r    <= have_best_r;
      idx_out_r  <= have_best_r ? best_idx_r : '0;
      dist_out_r <= have_best_r ? OUT_DIST_W'(best_dist_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      best_dist_r <= DIST_MAX;
      best_idx_r  <= '0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (clr_best) begin
        best_dist_r <= DIST_MAX;
        best_idx_r  <= '0;
        have_best_r <= 1'b0;
      end else if (upd_best) begin
        best_dist_r <= dist_sq;
        best_idx_r  <= head.idx;
        have_best_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_DIST_W - IDX_W){1'b0}}, dist_out_r, idx_out_r};

endmodule

// ===== hw/rtl/nearest_node_to_ray_search_core.sv =====
// Top level of the nearest node to ray search block.
//
// Input stream: a header item (in_tuser = 0) loads the query origin, the Q1.15
// direction and the mode; node items (in_tuser = 1) carry point positions.
// in_tlast on any item closes the query and causes one result item on the
// output stream: found in out_tuser, index and squared distance in out_tdata.
// The front end takes an item per cycle while its two-entry queue has room.
// The distance engine shares three multipliers, one per axis, over its steps:
// a node in point mode takes squares and compare; in ray mode it takes dot
// product, sum of t, two partial products of dir*t, error rounding, squares,
// compare, or stops after the sum when t is negative. A header is taken in
// the idle step and a closing mark adds the result step. Sustained input rate
// is set by that engine sequence once the queue fills.
// A stalled output holds its result register; the engine then waits in the
// result step and the queue backs up to in_tready.
// Synchronous reset clears the query to zero, the search state and the queue.
module nearest_node_to_ray_search_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pos_x, pos_y, pos_z, dir_x, dir_y, dir_z, mode, zero fill
  input  logic [nnr_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // best_index, best_dist_sq, zero fill
  output logic [nnr_pkg::OUT_DATA_W-1:0] out_tdata,
  // found
  output logic                           out_tuser
);
  import nnr_pkg::*;

  q_entry_t wr_entry;
  q_entry_t head;
  logic     push;
  logic     pop;
  logic     q_empty;
  logic     q_full;

  nnr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .entry     (wr_entry)
  );

  nnr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  nnr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_empty    (q_empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("result without a node carries nonzero fields");

  a_dist_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:IDX_W+DIST_W] == '0)
    else $error("squared distance above saturation limit");

  a_reset_clean: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("block not clean after reset");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_empty |-> !pop)
    else $error("queue popped while empty");

endmodule

// ===== bench/nearest_node_to_ray_search_core_tb.sv =====
// Self-checking bench for the nearest node to ray search core, streams and predictor.
module nearest_node_to_ray_search_core_tb;
  import nnr_pkg::*;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_NODE    = 1'b1;
  localparam logic MODE_POINT   = 1'b0;
  localparam logic MODE_RAY     = 1'b1;
  localparam int   RANDOM_ITEMS = 1450;
  localparam int   HOLD_CYCLES  = 400;
  localparam int   DRAIN_CYCLES = 40;
  localparam longint DIST_CAP   = (64'sd1 <<< DIST_W) - 1;
  localparam longint ONE_Q30    = 64'sd1 <<< ROUND_SH;
  localparam longint HALF_Q30   = 64'sd1 <<< (ROUND_SH - 1);

  typedef struct {
    logic                  found;
    logic [IDX_W-1:0]      index;
    logic [OUT_DIST_W-1:0] dist_sq;
  } nearest_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // query and search state of the predictor
  logic signed [COORD_W-1:0] q_origin [AXES];
  logic signed [DIR_W-1:0]   q_dir [AXES];
  logic                      q_mode;
  logic [CNT_W-1:0]          node_count;
  logic [DIST_W-1:0]         best_dist;
  logic [IDX_W-1:0]          best_idx;
  logic                      have_best;

  nearest_t awaited_nearest [$];
  nearest_t want;

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  ray_queries = 0;
  bit  tx_fast = 1'b0;
  bit  rx_fast = 1'b0;
  int  hold_reqs = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  int  rx_gap_left = 0;

  nearest_node_to_ray_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("nearest_node_to_ray_search_core_tb NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void clear_search();
    node_count = '0;
    best_dist  = DIST_MAX;
    best_idx   = '0;
    have_best  = 1'b0;
  endfunction

  function automatic void nearest_step(logic kind, logic [IN_DATA_W-1:0] data, logic last);
    longint   p [AXES];
    longint   d [AXES];
    longint   e [AXES];
    longint   proj;
    longint   sum;
    bit       eligible;
    nearest_t res;
    for (int i = 0; i < AXES; i++) p[i] = longint'($signed(data[i*COORD_W +: COORD_W]));
    if (kind == KIND_HEADER) begin
      for (int i = 0; i < AXES; i++) begin
        q_origin[i] = p[i][COORD_W-1:0];
        q_dir[i]    = data[DIR_LSB + i*DIR_W +: DIR_W];
      end
      q_mode = data[MODE_BIT];
      clear_search();
    end else if (node_count < CNT_W'(MAX_NODES)) begin
      eligible = 1'b1;
      sum = 0;
      for (int i = 0; i < AXES; i++) d[i] = p[i] - longint'(q_origin[i]);
      if (q_mode == MODE_RAY) begin
        proj = 0;
        for (int i = 0; i < AXES; i++) proj += d[i] * longint'(q_dir[i]);
        if (proj < 0) begin
          eligible = 1'b0;
        end else begin
          for (int i = 0; i < AXES; i++) begin
            e[i] = (d[i] * ONE_Q30 - longint'(q_dir[i]) * proj + HALF_Q30) >>> ROUND_SH;
            sum += e[i] * e[i];
          end
        end
      end else begin
        for (int i = 0; i < AXES; i++) sum += d[i] * d[i];
      end
      if (sum > DIST_CAP) sum = DIST_CAP;
      if (eligible && (!have_best || sum[DIST_W-1:0] < best_dist)) begin
        best_dist = sum[DIST_W-1:0];
        best_idx  = node_count[IDX_W-1:0];
        have_best = 1'b1;
      end
      node_count++;
    end
    if (last) begin
      res.found   = have_best;
      res.index   = have_best ? best_idx : '0;
      res.dist_sq = have_best ? OUT_DIST_W'(best_dist) : '0;
      awaited_nearest.push_back(res);
      clear_search();
    end
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_item(int x, int y, int z, int dx, int dy,
                                                     int dz, logic mode);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[0*COORD_W +: COORD_W]           = x[COORD_W-1:0];
    w[1*COORD_W +: COORD_W]           = y[COORD_W-1:0];
    w[2*COORD_W +: COORD_W]           = z[COORD_W-1:0];
    w[DIR_LSB + 0*DIR_W +: DIR_W]     = dx[DIR_W-1:0];
    w[DIR_LSB + 1*DIR_W +: DIR_W]     = dy[DIR_W-1:0];
    w[DIR_LSB + 2*DIR_W +: DIR_W]     = dz[DIR_W-1:0];
    w[MODE_BIT]                       = mode;
    return w;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 1048575)) - 524288;
  endfunction

  function automatic int rand_dir();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int near(int c, int spread);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data,
                           input logic last);
    int gap;
    gap = tx_fast ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    nearest_step(kind, data, last);
    items_sent++;
  endtask

  task automatic send_node(input int x, input int y, input int z, input logic last);
    send_item(KIND_NODE, pack_item(x, y, z, 0, 0, 0, MODE_POINT), last);
  endtask

  task automatic send_header(input int x, input int y, input int z, input int dx, input int dy,
                             input int dz, input logic mode, input logic last);
    if (mode == MODE_RAY) ray_queries++;
    send_item(KIND_HEADER, pack_item(x, y, z, dx, dy, dz, mode), last);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_nearest.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // optional random header and a run of nodes around the query origin
  task automatic run_query(input int nodes, input bit with_header);
    int   o [3];
    int   dv [3];
    int   spread;
    int   a;
    logic mode;
    logic [IN_DATA_W-1:0] w;
    if (with_header) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = rand_coord();
        if ($urandom_range(0, 15) == 0) o[i] = $urandom_range(0, 1) ? 524287 : -524288;
        dv[i] = 0;
      end
      case ($urandom_range(0, 4))
        0: begin
          a = $urandom_range(0, 2);
          dv[a] = $urandom_range(0, 1) ? 32767 : -32768;
        end
        1: for (int i = 0; i < 3; i++) dv[i] = rand_dir();
        2: ;
        3: begin
          a = $urandom_range(0, 2);
          dv[a] = $urandom_range(0, 1) ? 23170 : -23170;
          dv[(a + 1) % 3] = $urandom_range(0, 1) ? 23170 : -23170;
        end
        default: for (int i = 0; i < 3; i++) dv[i] = $urandom_range(0, 1) ? 32767 : -32768;
      endcase
      mode = 1'($urandom_range(0, 1));
      send_header(o[0], o[1], o[2], dv[0], dv[1], dv[2], mode, nodes == 0);
    end
    case ($urandom_range(0, 3))
      0: spread = 3;
      1: spread = 100;
      2: spread = 5000;
      default: spread = 524288;
    endcase
    for (int k = 0; k < nodes; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        w = pack_item(near(int'(q_origin[0]), spread), near(int'(q_origin[1]), spread),
                      near(int'(q_origin[2]), spread), rand_dir(), rand_dir(), rand_dir(),
                      1'($urandom_range(0, 1)));
      end else begin
        w = pack_item(near(int'(q_origin[0]), spread), near(int'(q_origin[1]), spread),
                      near(int'(q_origin[2]), spread), 0, 0, 0, MODE_POINT);
      end
      send_item(KIND_NODE, w, k == nodes - 1);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++) begin
      send_item(1'($urandom_range(0, 1)),
                pack_item(rand_coord(), rand_coord(), rand_coord(), rand_dir(), rand_dir(),
                          rand_dir(), 1'($urandom_range(0, 1))),
                $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic test_nodes_before_header();
    send_node(7, -3, 2, 1'b0);
    send_node(-1, 1, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_point_search();
    send_header(0, 0, 0, 32767, -32768, 1, MODE_POINT, 1'b0);
    send_node(524287, 524287, 524287, 1'b0);
    send_node(-524288, -524288, -524288, 1'b0);
    send_node(5, 0, 0, 1'b0);
    send_node(0, -5, 0, 1'b0);
    send_node(3, 4, 0, 1'b0);
    send_node(0, 0, -5, 1'b1);
    wait_idle();
  endtask

  task automatic test_ray_search();
    send_header(100, -200, 300, 32767, 0, 0, MODE_RAY, 1'b0);
    send_node(99, -200, 300, 1'b0);
    send_node(100, -190, 300, 1'b0);
    send_node(5000, -200, 310, 1'b0);
    send_node(524287, -524288, -524288, 1'b0);
    send_node(2000, -195, 300, 1'b1);
    wait_idle();
  endtask

  task automatic test_ray_corner_cases();
    // zero direction falls back to distance from the origin
    send_header(0, 0, 0, 0, 0, 0, MODE_RAY, 1'b0);
    send_node(3, 4, 0, 1'b0);
    send_node(1, 1, 1, 1'b1);
    send_header(524287, 524287, 524287, -32768, -32768, -32768, MODE_RAY, 1'b0);
    send_node(-524288, -524288, -524288, 1'b1);
    // every node behind the origin
    send_header(0, 0, 0, 32767, 0, 0, MODE_RAY, 1'b0);
    send_node(-5, 0, 0, 1'b1);
    // empty query, then a node reusing the kept query
    send_header(-524288, 524287, 0, 32767, 0, 0, MODE_RAY, 1'b1);
    send_node(10, 3, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_output_stall();
    hold_reqs++;
    tx_fast = 1'b1;
    for (int q = 0; q < 10; q++) run_query(1 + q % 3, 1'b1);
    wait_idle();
    tx_fast = 1'b0;
  endtask

  task automatic test_random();
    int stop_at;
    int r;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      tx_fast = ($urandom_range(0, 7) == 0);
      rx_fast = ($urandom_range(0, 7) == 0);
      r = $urandom_range(0, 99);
      if (r < 75) run_query(($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                         : $urandom_range(1, 8), 1'b1);
      else if (r < 83) run_query(0, 1'b1);
      else if (r < 90) run_query($urandom_range(1, 6), 1'b0);
      else send_noise();
    end
    run_query($urandom_range(1, 5), 1'b1);
    wait_idle();
    tx_fast = 1'b0;
    rx_fast = 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_reqs != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_fast) begin
      out_tready <= 1'b1;
    end else if (rx_gap_left > 0) begin
      rx_gap_left <= rx_gap_left - 1;
      out_tready  <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 2) == 0) rx_gap_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (awaited_nearest.size() == 0) begin
        errors++;
        $display("%0t: unexpected result found %0b index %0d dist %0d", $time, out_tuser,
                 out_tdata[IDX_W-1:0], out_tdata[IDX_W +: OUT_DIST_W]);
      end else begin
        want = awaited_nearest.pop_front();
        if (out_tuser !== want.found) begin
          errors++;
          $display("%0t: found mismatch expected %0b actual %0b", $time, want.found,
                   out_tuser);
        end
        if (out_tdata[IDX_W-1:0] !== want.index) begin
          errors++;
          $display("%0t: best_index mismatch expected %0d actual %0d", $time, want.index,
                   out_tdata[IDX_W-1:0]);
        end
        if (out_tdata[IDX_W +: OUT_DIST_W] !== want.dist_sq) begin
          errors++;
          $display("%0t: best_dist_sq mismatch expected %0d actual %0d", $time, want.dist_sq,
                   out_tdata[IDX_W +: OUT_DIST_W]);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < AXES; i++) begin
      q_origin[i] = '0;
      q_dir[i]    = '0;
    end
    q_mode = MODE_POINT;
    clear_search();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_nodes_before_header();
    test_point_search();
    test_ray_search();
    test_ray_corner_cases();
    test_output_stall();
    test_random();

    $display("Sent %0d items (%0d ray queries) and checked %0d results.", items_sent,
             ray_queries, results_seen);
    $display("Included point and ray corner queries and a %0d-cycle output stall.",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("nearest_node_to_ray_search_core_tb OK");
    end else begin
      $display("nearest_node_to_ray_search_core_tb NOT OK");
    end
    $finish;
  end

endmodule
